>>> design/tnp_pkg.sv
// Package for the number token parser: character codes, radix, kind and error codes,
// the queue item type and the digit classifier.
// No dependencies.
`default_nettype none

package tnp_pkg;

	// Characters the parser looks at
	localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
	localparam logic [7:0] CH_NINE  = 8'h39; // '9'
	localparam logic [7:0] CH_LA    = 8'h61; // 'a'
	localparam logic [7:0] CH_LF    = 8'h66; // 'f'
	localparam logic [7:0] CH_UA    = 8'h41; // 'A'
	localparam logic [7:0] CH_UF    = 8'h46; // 'F'
	localparam logic [7:0] CH_LE    = 8'h65; // 'e'
	localparam logic [7:0] CH_UE    = 8'h45; // 'E'
	localparam logic [7:0] CH_UNDER = 8'h5F; // '_'
	localparam logic [7:0] CH_DOT   = 8'h2E; // '.'
	localparam logic [7:0] CH_PLUS  = 8'h2B; // '+'
	localparam logic [7:0] CH_MINUS = 8'h2D; // '-'
	localparam logic [7:0] CH_LX    = 8'h78; // 'x'
	localparam logic [7:0] CH_LB    = 8'h62; // 'b'
	localparam logic [7:0] CH_LO    = 8'h6F; // 'o'
	localparam logic [7:0] CH_LI    = 8'h69; // 'i'
	localparam logic [7:0] CH_LN    = 8'h6E; // 'n'

	// Radix codes
	localparam logic [1:0] RADIX_DEC = 2'd0;
	localparam logic [1:0] RADIX_HEX = 2'd1;
	localparam logic [1:0] RADIX_BIN = 2'd2;
	localparam logic [1:0] RADIX_OCT = 2'd3;

	// Whole-token special spellings
	localparam logic [1:0] SPEC_NONE = 2'd0;
	localparam logic [1:0] SPEC_PINF = 2'd1;
	localparam logic [1:0] SPEC_NINF = 2'd2;
	localparam logic [1:0] SPEC_NAN  = 2'd3;

	// Result kinds
	localparam logic [2:0] KIND_INT32 = 3'd0;
	localparam logic [2:0] KIND_INT64 = 3'd1;
	localparam logic [2:0] KIND_FLOAT = 3'd2;
	localparam logic [2:0] KIND_PINF  = 3'd3;
	localparam logic [2:0] KIND_NINF  = 3'd4;
	localparam logic [2:0] KIND_NAN   = 3'd5;
	localparam logic [2:0] KIND_ERROR = 3'd6;

	// Error codes
	localparam logic [3:0] ERR_NONE         = 4'd0;
	localparam logic [3:0] ERR_LEAD_US      = 4'd1;
	localparam logic [3:0] ERR_US_NO_DIGIT  = 4'd2;
	localparam logic [3:0] ERR_LEAD_DOT     = 4'd3;
	localparam logic [3:0] ERR_DOT_NO_DIGIT = 4'd4;
	localparam logic [3:0] ERR_E_NO_DIGIT   = 4'd5;
	localparam logic [3:0] ERR_TRAIL_US     = 4'd6;
	localparam logic [3:0] ERR_TRAIL_DOT    = 4'd7;
	localparam logic [3:0] ERR_TRAIL_EXP    = 4'd8;
	localparam logic [3:0] ERR_FLT_ZERO     = 4'd9;
	localparam logic [3:0] ERR_FLT_SGN_ZERO = 4'd10;
	localparam logic [3:0] ERR_INT_ZERO     = 4'd11;
	localparam logic [3:0] ERR_INT_SGN_ZERO = 4'd12;
	localparam logic [3:0] ERR_BAD_INT      = 4'd13;
	localparam logic [3:0] ERR_NEG_PREFIX   = 4'd14;

	// One classified character on its way from front to back
	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
		logic [1:0] radix;
		logic       restart;   // prefix seen: clear number state before this char
		logic       dig_ok;    // char is a digit in radix
		logic [3:0] dig_val;
		logic [1:0] special;   // inf/nan spelling, valid on last_char
	} tnp_item_t;

	function automatic logic is_dec_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// {ok, value} of c as a digit in the given radix
	function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] radix);
		logic [4:0] d;
		logic       ok;
		d  = 5'd31;
		ok = 1'b0;
		if (is_dec_digit(c)) begin
			d = {1'b0, 4'(c - CH_ZERO)};
		end else if (c >= CH_LA && c <= CH_LF) begin
			d = 5'(c - CH_LA) + 5'd10;
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = 5'(c - CH_UA) + 5'd10;
		end
		case (radix)
			RADIX_HEX: ok = (d < 5'd16);
			RADIX_BIN: ok = (d < 5'd2);
			RADIX_OCT: ok = (d < 5'd8);
			default:   ok = (d < 5'd10);
		endcase
		return {ok, d[3:0]};
	endfunction

endpackage

`default_nettype wire

>>> design/tnp_if.sv
// Stream interfaces of the number token parser: the character channel and the result channel.
// Depends on nothing; widths are the fixed field widths.
`default_nettype none

interface tnp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;
	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface tnp_result_if;
	logic               valid;
	logic               ready;
	logic [2:0]         value_kind;
	logic signed [63:0] int_value;
	logic [3:0]         error_code;
	modport source (output valid, output value_kind, output int_value, output error_code,
		input ready);
	modport sink (input valid, input value_kind, input int_value, input error_code,
		output ready);
endinterface

`default_nettype wire

>>> design/tnp_front.sv
// Front end: tracks token position, head characters and radix prefix, and classifies each char.
// Depends on tnp_pkg.
`default_nettype none

module tnp_front
	import tnp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] char_code,
	input  wire logic       last_char,
	input  wire logic       accept,
	output tnp_item_t       item
);

	logic [2:0]  cnt_q, cnt_n;   // saturates at 5
	logic [23:0] head_q, head_n;
	logic [7:0]  fourth_q, fourth_n;
	logic [1:0]  radix_q, radix_eff, new_radix;
	logic        restart;
	logic [4:0]  dig;
	logic        head_inf, head_nan, tail_inf, tail_nan;
	logic [1:0]  special;

	always_comb begin
		restart = (cnt_q == 3'd2) && (head_q[7:0] == CH_ZERO) &&
			(head_q[15:8] == CH_LX || head_q[15:8] == CH_LB || head_q[15:8] == CH_LO);
		if (head_q[15:8] == CH_LX) begin
			new_radix = RADIX_HEX;
		end else if (head_q[15:8] == CH_LB) begin
			new_radix = RADIX_BIN;
		end else begin
			new_radix = RADIX_OCT;
		end
		radix_eff = restart ? new_radix : radix_q;

		head_n   = head_q;
		fourth_n = fourth_q;
		case (cnt_q)
			3'd0:    head_n[7:0]   = char_code;
			3'd1:    head_n[15:8]  = char_code;
			3'd2:    head_n[23:16] = char_code;
			3'd3:    fourth_n      = char_code;
			default: ;
		endcase
		cnt_n = (cnt_q == 3'd5) ? cnt_q : cnt_q + 3'd1;

		head_inf = head_n[7:0] == CH_LI && head_n[15:8] == CH_LN && head_n[23:16] == CH_LF;
		head_nan = head_n[7:0] == CH_LN && head_n[15:8] == CH_LA && head_n[23:16] == CH_LN;
		tail_inf = head_n[15:8] == CH_LI && head_n[23:16] == CH_LN && fourth_n == CH_LF;
		tail_nan = head_n[15:8] == CH_LN && head_n[23:16] == CH_LA && fourth_n == CH_LN;

		if (cnt_n == 3'd4 && head_n[7:0] == CH_MINUS && tail_inf) begin
			special = SPEC_NINF;
		end else if ((cnt_n == 3'd3 && head_inf) ||
			(cnt_n == 3'd4 && head_n[7:0] == CH_PLUS && tail_inf)) begin
			special = SPEC_PINF;
		end else if ((cnt_n == 3'd3 && head_nan) ||
			(cnt_n == 3'd4 && (head_n[7:0] == CH_PLUS || head_n[7:0] == CH_MINUS) &&
			tail_nan)) begin
			special = SPEC_NAN;
		end else begin
			special = SPEC_NONE;
		end

		dig = digit_of(char_code, radix_eff);

		item.char_code = char_code;
		item.last_char = last_char;
		item.radix     = radix_eff;
		item.restart   = restart;
		item.dig_ok    = dig[4];
		item.dig_val   = dig[3:0];
		item.special   = special;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			head_q   <= '0;
			fourth_q <= '0;
			radix_q  <= RADIX_DEC;
		end else if (accept) begin
			if (last_char) begin
				cnt_q    <= '0;
				head_q   <= '0;
				fourth_q <= '0;
				radix_q  <= RADIX_DEC;
			end else begin
				cnt_q    <= cnt_n;
				head_q   <= head_n;
				fourth_q <= fourth_n;
				radix_q  <= radix_eff;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/tnp_queue.sv
// Short register queue of classified characters between front and back.
// Depends on tnp_pkg.
`default_nettype none

module tnp_queue
	import tnp_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push_valid,
	output logic            push_ready,
	input  wire tnp_item_t  push_item,
	output logic            pop_valid,
	input  wire logic       pop_ready,
	output tnp_item_t       pop_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tnp_item_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> design/tnp_back.sv
// Back end: applies the per-character rules and accumulates the integer, then holds the final
// token state in a result stage and derives kind, value and error code from it. Uses tnp_pkg.
`default_nettype none

module tnp_back
	import tnp_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pop_valid,
	output logic               pop_ready,
	input  wire tnp_item_t     item,
	output logic               res_valid,
	input  wire logic          res_ready,
	output logic [2:0]         value_kind,
	output logic signed [63:0] int_value,
	output logic [3:0]         error_code
);

	typedef struct packed {
		logic [23:0] kh;
		logic [1:0]  kc;
		logic [3:0]  ptrail;
		logic [63:0] acc;
		logic        neg;
		logic        frac;
		logic        ovf;
		logic [3:0]  ferr;
		logic        dec;
		logic [1:0]  special;
	} tnp_final_t;

	// number state; kc saturates at 3
	logic [23:0] kh_q, e_kh, n_kh;
	logic [1:0]  kc_q, e_kc, n_kc;
	logic        pnone_q, e_pnone, n_pnone;
	logic        pdig_q, e_pdig, n_pdig;
	logic [3:0]  ptrail_q, e_ptrail, n_ptrail;
	logic [63:0] acc_q, e_acc, n_acc;
	logic        neg_q, e_neg, n_neg;
	logic        frac_q, e_frac, n_frac;
	logic        ovf_q, e_ovf, n_ovf;
	logic [3:0]  ferr_q, e_ferr, n_ferr;

	logic        do_keep, set_prev, fin_free, do_pop;
	logic [7:0]  c;
	logic [67:0] scaled, sum;
	logic        sum_big;

	tnp_final_t  fin_s2;
	logic        fin_vld_s2;

	assign fin_free  = !fin_vld_s2 || res_ready;
	assign pop_ready = !item.last_char || fin_free;
	assign do_pop    = pop_valid && pop_ready;
	assign c         = item.char_code;

	always_comb begin
		if (item.restart) begin
			e_kh = '0; e_kc = '0; e_pnone = 1'b1; e_pdig = 1'b0; e_ptrail = ERR_NONE;
			e_acc = '0; e_neg = 1'b0; e_frac = 1'b0; e_ovf = 1'b0; e_ferr = ERR_NONE;
		end else begin
			e_kh = kh_q; e_kc = kc_q; e_pnone = pnone_q; e_pdig = pdig_q; e_ptrail = ptrail_q;
			e_acc = acc_q; e_neg = neg_q; e_frac = frac_q; e_ovf = ovf_q; e_ferr = ferr_q;
		end

		case (item.radix)
			RADIX_HEX: scaled = {e_acc, 4'b0};
			RADIX_BIN: scaled = {3'b0, e_acc, 1'b0};
			RADIX_OCT: scaled = {1'b0, e_acc, 3'b0};
			default:   scaled = {1'b0, e_acc, 3'b0} + {3'b0, e_acc, 1'b0};
		endcase
		sum     = scaled + {64'b0, item.dig_val};
		sum_big = (sum[67:64] != 4'b0) || (sum[63] && (sum[62:0] != 63'b0));

		n_kh = e_kh; n_kc = e_kc; n_pnone = e_pnone; n_pdig = e_pdig; n_ptrail = e_ptrail;
		n_acc = e_acc; n_neg = e_neg; n_frac = e_frac; n_ovf = e_ovf; n_ferr = e_ferr;

		do_keep  = 1'b0;
		set_prev = 1'b0;
		if (e_ferr == ERR_NONE) begin
			if (c == CH_UNDER) begin
				if (e_pnone) begin
					n_ferr = ERR_LEAD_US;
				end else if (!e_pdig) begin
					n_ferr = ERR_US_NO_DIGIT;
				end else begin
					set_prev = 1'b1;
				end
			end else if (c == CH_DOT) begin
				if (e_pnone) begin
					n_ferr = ERR_LEAD_DOT;
				end else if (!e_pdig) begin
					n_ferr = ERR_DOT_NO_DIGIT;
				end else begin
					do_keep  = 1'b1;
					set_prev = 1'b1;
				end
			end else if (c == CH_LE) begin
				if (item.radix != RADIX_HEX && !e_pdig) begin
					n_ferr = ERR_E_NO_DIGIT;
				end else begin
					do_keep  = 1'b1;
					set_prev = 1'b1;
				end
			end else begin
				do_keep  = 1'b1;
				set_prev = 1'b1;
			end
		end

		if (do_keep) begin
			case (e_kc)
				2'd0:    n_kh[7:0]   = c;
				2'd1:    n_kh[15:8]  = c;
				2'd2:    n_kh[23:16] = c;
				default: ;
			endcase
			if (c == CH_DOT || c == CH_LE || c == CH_UE) begin
				n_frac = 1'b1;
			end
			if (e_kc == 2'd0 && (c == CH_PLUS || c == CH_MINUS)) begin
				n_neg = (c == CH_MINUS);
			end else if (!item.dig_ok) begin
				n_ovf = 1'b1;
			end else if (!e_ovf) begin
				if (sum_big) begin
					n_ovf = 1'b1;
				end else begin
					n_acc = sum[63:0];
				end
			end
			n_kc = (e_kc == 2'd3) ? e_kc : e_kc + 2'd1;
		end

		if (set_prev) begin
			n_pnone = 1'b0;
			n_pdig  = item.dig_ok;
			if (c == CH_UNDER) begin
				n_ptrail = ERR_TRAIL_US;
			end else if (c == CH_DOT) begin
				n_ptrail = ERR_TRAIL_DOT;
			end else if (c == CH_LE || c == CH_UE || c == CH_MINUS || c == CH_PLUS) begin
				n_ptrail = ERR_TRAIL_EXP;
			end else begin
				n_ptrail = ERR_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kh_q <= '0; kc_q <= '0; pnone_q <= 1'b1; pdig_q <= 1'b0; ptrail_q <= ERR_NONE;
			acc_q <= '0; neg_q <= 1'b0; frac_q <= 1'b0; ovf_q <= 1'b0; ferr_q <= ERR_NONE;
		end else if (do_pop) begin
			if (item.last_char) begin
				kh_q <= '0; kc_q <= '0; pnone_q <= 1'b1; pdig_q <= 1'b0; ptrail_q <= ERR_NONE;
				acc_q <= '0; neg_q <= 1'b0; frac_q <= 1'b0; ovf_q <= 1'b0; ferr_q <= ERR_NONE;
			end else begin
				kh_q <= n_kh; kc_q <= n_kc; pnone_q <= n_pnone; pdig_q <= n_pdig;
				ptrail_q <= n_ptrail; acc_q <= n_acc; neg_q <= n_neg; frac_q <= n_frac;
				ovf_q <= n_ovf; ferr_q <= n_ferr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_s2 <= 1'b0;
		end else if (fin_free) begin
			fin_vld_s2 <= do_pop && item.last_char;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_free && do_pop && item.last_char) begin
			fin_s2.kh      <= n_kh;
			fin_s2.kc      <= n_kc;
			fin_s2.ptrail  <= n_pnone ? ERR_NONE : n_ptrail;
			fin_s2.acc     <= n_acc;
			fin_s2.neg     <= n_neg;
			fin_s2.frac    <= n_frac;
			fin_s2.ovf     <= n_ovf;
			fin_s2.ferr    <= n_ferr;
			fin_s2.dec     <= (item.radix == RADIX_DEC);
			fin_s2.special <= item.special;
		end
	end

	// result decode from the held final state
	logic [7:0] kh0, kh1, kh2;
	logic       zero_digit, sign_zero, has_sign, float_ok;
	logic [3:0] fe;

	assign kh0 = fin_s2.kh[7:0];
	assign kh1 = fin_s2.kh[15:8];
	assign kh2 = fin_s2.kh[23:16];
	assign zero_digit = (kh0 == CH_ZERO) && is_dec_digit(kh1);
	assign sign_zero  = (kh0 == CH_MINUS || kh0 == CH_PLUS) && (kh1 == CH_ZERO) &&
		is_dec_digit(kh2);
	assign has_sign   = (fin_s2.kc != 2'd0) && (kh0 == CH_PLUS || kh0 == CH_MINUS);

	always_comb begin
		value_kind = KIND_ERROR;
		int_value  = '0;
		error_code = ERR_NONE;
		fe         = fin_s2.ferr;
		float_ok   = 1'b0;
		case (fin_s2.special)
			SPEC_PINF: value_kind = KIND_PINF;
			SPEC_NINF: value_kind = KIND_NINF;
			SPEC_NAN:  value_kind = KIND_NAN;
			default: begin
				if (fe == ERR_NONE) begin
					fe = fin_s2.ptrail;
				end
				if (fe == ERR_NONE && fin_s2.dec && fin_s2.frac) begin
					if (fin_s2.kc > 2'd1 && zero_digit) begin
						fe = ERR_FLT_ZERO;
					end else if (fin_s2.kc > 2'd2 && sign_zero) begin
						fe = ERR_FLT_SGN_ZERO;
					end else begin
						float_ok = 1'b1;
					end
				end
				if (float_ok) begin
					value_kind = KIND_FLOAT;
				end else begin
					if (fe == ERR_NONE && fin_s2.dec) begin
						if (fin_s2.kc > 2'd1 && kh0 == CH_ZERO) begin
							fe = ERR_INT_ZERO;
						end else if (fin_s2.kc > 2'd2 && sign_zero) begin
							fe = ERR_INT_SGN_ZERO;
						end
					end
					if (fe == ERR_NONE) begin
						if (fin_s2.ovf || fin_s2.kc <= {1'b0, has_sign} ||
							(!fin_s2.neg && fin_s2.acc[63])) begin
							fe = ERR_BAD_INT;
						end else if (fin_s2.neg && fin_s2.acc != 64'b0 && !fin_s2.dec) begin
							fe = ERR_NEG_PREFIX;
						end
					end
					if (fe != ERR_NONE) begin
						value_kind = KIND_ERROR;
						error_code = fe;
					end else if (fin_s2.neg) begin
						int_value  = -$signed(fin_s2.acc);
						value_kind = (fin_s2.acc[63:32] == 32'b0 &&
							(!fin_s2.acc[31] || fin_s2.acc[30:0] == 31'b0)) ?
							KIND_INT32 : KIND_INT64;
					end else begin
						int_value  = $signed(fin_s2.acc);
						value_kind = (fin_s2.acc[63:31] == 33'b0) ? KIND_INT32 : KIND_INT64;
					end
				end
			end
		endcase
	end

	assign res_valid = fin_vld_s2;

endmodule

`default_nettype wire

>>> design/toml_number_token_parser_core.sv
// Number token parser. A token's result word is registered in the result stage once its last char
// has passed the queue and the back while that stage is free. Throughput: one char per cycle, set by
// the accumulator shift-add loop in the back, unless a last char waits for the result stage to free.
// Chars are accepted while the front queue has room, also while a result waits to be taken.
// Reset: arst_n clears token state, the queue and the result stage at once; no clearing pass.
// Depends on tnp_pkg, tnp_if, tnp_front, tnp_queue and tnp_back.
`default_nettype none

module toml_number_token_parser_core
	import tnp_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	tnp_char_if.sink       chars,
	tnp_result_if.source   results
);

	// front to queue
	tnp_item_t front_item;
	logic      push_ready;
	logic      accept;

	// queue to back
	tnp_item_t back_item;
	logic      pop_valid;
	logic      pop_ready;

	// Take a char whenever the queue has room; the front classifies it in the same cycle.
	assign chars.ready = push_ready;
	assign accept      = chars.valid && push_ready;

	tnp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (chars.char_code),
		.last_char (chars.last_char),
		.accept    (accept),
		.item      (front_item)
	);

	// Decouple the front from the back so a stalled result never blocks char intake at once.
	tnp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (chars.valid),
		.push_ready (push_ready),
		.push_item  (front_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (back_item)
	);

	// Apply the char rules, accumulate, and hold the final token state for the result.
	tnp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.item       (back_item),
		.res_valid  (results.valid),
		.res_ready  (results.ready),
		.value_kind (results.value_kind),
		.int_value  (results.int_value),
		.error_code (results.error_code)
	);

`ifndef SYNTHESIS
	// Error kind and nonzero error code go together.
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> ((results.value_kind == KIND_ERROR) == (results.error_code != ERR_NONE)))
		else $error("error kind and error code disagree");

	// Only integer kinds carry a value.
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.value_kind != KIND_INT32 && results.value_kind != KIND_INT64)
		|-> (results.int_value == 64'sd0))
		else $error("non-integer result carries a value");

	// A 32-bit kind fits in 32 signed bits.
	a_int32_range: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.value_kind == KIND_INT32)
		|-> (results.int_value[63:31] == 33'b0 || results.int_value[63:31] == {33{1'b1}}))
		else $error("int32 result out of range");
`endif

endmodule

`default_nettype wire
